// File: hdl/fnp_pkg.sv
package fnp_pkg;

    localparam int DEFAULT_MAX_DIGITS = 2;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_TEE   = 8'h54;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [6:0] ACC_MAX = 7'd127;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic       tool_found;
        logic [6:0] tool_number;
    } t_out_item;

endpackage

// File: hdl/fnp_scan.sv
module fnp_scan
    import fnp_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int LEN_W = $clog2(MAX_DIGITS + 3);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_DIGITS + 2);
    localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        PH_ZEROS,
        PH_SPACE,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    logic             r_match, n_match;
    logic [6:0]       r_value, n_value;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_tee, n_tee;
    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    logic [6:0]       r_acc, n_acc;
    logic             r_rem, n_rem;

    logic [7:0]  c;
    logic        c_digit;
    logic        c_blank;
    logic [10:0] acc_sum;
    logic [6:0]  acc_sat;

    assign c       = i_item.char_code;
    assign c_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign c_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    assign acc_sum = ({4'b0, r_acc} * 11'd10) + {7'b0, c[3:0]};
    assign acc_sat = (acc_sum > {4'b0, ACC_MAX}) ? ACC_MAX : acc_sum[6:0];

    always_comb begin
        n_match = r_match;
        n_value = r_value;
        n_len   = r_len;
        n_tee   = r_tee;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        n_rem   = r_rem;

        if (c == CHAR_SLASH) begin
            n_match = 1'b0;
            n_value = '0;
            n_len   = '0;
            n_tee   = 1'b0;
            n_phase = PH_ZEROS;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_rem   = 1'b0;
        end else if (c == CHAR_DOT) begin
            if (!r_match && r_tee && (r_len >= LEN_MIN) && (r_len <= LEN_MAX) &&
                r_rem && !r_neg && (r_acc != '0)) begin
                n_match = 1'b1;
                n_value = r_acc;
            end
            n_len   = '0;
            n_tee   = 1'b0;
            n_phase = PH_ZEROS;
            n_neg   = 1'b0;
            n_acc   = '0;
            n_rem   = 1'b0;
        end else begin
            if (r_len == '0) begin
                n_tee = (c == CHAR_TEE);
            end else begin
                if ((r_phase == PH_ZEROS) && (c != CHAR_ZERO)) begin
                    n_rem = 1'b1;
                end
                if ((r_phase == PH_SPACE) ||
                    ((r_phase == PH_ZEROS) && (c != CHAR_ZERO))) begin
                    if (c_blank) begin
                        n_phase = PH_SPACE;
                    end else if ((c == CHAR_PLUS) || (c == CHAR_MINUS)) begin
                        n_neg   = (c == CHAR_MINUS);
                        n_phase = PH_DIGITS;
                    end else if (c_digit) begin
                        n_acc   = acc_sat;
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end else if (r_phase == PH_DIGITS) begin
                    if (c_digit) begin
                        n_acc = acc_sat;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            if (r_len < LEN_CAP) begin
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    assign o_result.tool_found  = n_match;
    assign o_result.tool_number = n_match ? n_value : 7'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_char)) begin
            r_match <= 1'b0;
            r_value <= '0;
            r_len   <= '0;
            r_tee   <= 1'b0;
            r_phase <= PH_ZEROS;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_rem   <= 1'b0;
        end else if (i_step) begin
            r_match <= n_match;
            r_value <= n_value;
            r_len   <= n_len;
            r_tee   <= n_tee;
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
        end
    end

endmodule

// File: hdl/filename_tool_number_parser.sv
// Each input transaction's character goes to the input register; for a last character, the scan result then
// loads into the result register, which raises o_out_valid.
// Throughput: one character per cycle; the input register feeds the segment scanner,
// whose single-pass update lands in the result register.
// A held result stalls the input only when the character in the input register is a last character.
// Reset (synchronous, active low) empties both registers and clears all scan state.
module filename_tool_number_parser
    import fnp_pkg::*;
#(
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    t_out_item scan_result;

    assign advance    = r_in_valid && (!r_in.last_char || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    fnp_scan #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .o_result (scan_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in.last_char) begin
            r_out <= scan_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/fnp_checker.sv
module fnp_checker
    import fnp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // A stalled result transaction must hold its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.tool_found |-> o_out_data.tool_number == 7'd0)
        else $error("tool number set without a tool");

    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.tool_found |-> o_out_data.tool_number != 7'd0)
        else $error("tool found with number zero");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled input transaction must hold its value.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed while stalled");

endmodule

bind filename_tool_number_parser fnp_checker u_fnp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
